// ===== src/cprf_pkg.sv =====
// Shared types and constants for the console port with receive FIFO.
// Request and response beat layouts, command and offset codes, status bits.
// No dependencies.
package cprf_pkg;

   // Command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;

   // Register offsets within the four-byte window
   localparam logic [1:0] OFS_STATUS = 2'd0;
   localparam logic [1:0] OFS_DATA   = 2'd1;
   localparam logic [1:0] OFS_OUTPUT = 2'd2;

   // Status register bits
   localparam logic [7:0] STATUS_BASE  = 8'h40;
   localparam logic [7:0] STATUS_READY = 8'h80;
   localparam int         POP_BIT      = 7;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] offset;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_dropped;
      logic       irq_level;
   } rsp_type;

   // Requests from the port control into the FIFO
   typedef struct packed {
      logic push;
      logic pop;
      logic peek;
   } fifo_cmd_type;

   // FIFO occupancy flags
   typedef struct packed {
      logic empty;
      logic full;
      logic single;
   } fifo_sts_type;

endpackage

// ===== src/cprf_rx_fifo.sv =====
// Receive FIFO: ring of SLOTS bytes in a synchronous memory, one slot kept free.
// The head byte read is registered. Depends on cprf_pkg.
module cprf_rx_fifo import cprf_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  fifo_cmd_type cmd,
   input  logic [7:0]   push_byte,
   output fifo_sts_type sts,
   output logic [7:0]   head_byte
);

   localparam int IdxW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

   logic [7:0]      mem [SLOTS];
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [IdxW-1:0] head_next, tail_next;
   logic [7:0]      rd_ff;

   // Ring increments
   assign head_next = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;

   assign sts.empty  = (head_ff == tail_ff);
   assign sts.full   = (tail_next == head_ff);
   assign sts.single = (head_next == tail_ff);

   assign head_in = cmd.pop  ? head_next : head_ff;
   assign tail_in = cmd.push ? tail_next : tail_ff;

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Storage: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= push_byte;
      end
      if (cmd.peek) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign head_byte = rd_ff;

endmodule

// ===== src/console_port_with_receive_fifo_core.sv =====
// Console port with receive FIFO, top level.
// Each beat's response is registered; a data-register read with bytes waiting
// passes through ST_PEEK first, for the registered read of the FIFO memory.
// Takes one beat per cycle while rsp_ready holds, but no new beat in ST_PEEK.
// Reset (synchronous, active high) empties the FIFO and clears the latched and
// output bytes; the memory contents are not cleared.
module console_port_with_receive_fifo_core import cprf_pkg::*; #(
   parameter int FIFO_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_PEEK
   } state_type;

   state_type    state_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;
   logic [7:0]   latched_ff;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         accept;
   logic         peek_go;
   fifo_cmd_type fifo_cmd;
   fifo_sts_type fifo_sts;
   logic [7:0]   head_byte;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   cprf_rx_fifo #(.SLOTS(FIFO_SLOTS)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fifo_cmd),
      .push_byte (req_data.value),
      .sts       (fifo_sts),
      .head_byte (head_byte)
   );

   // Beat decode
   always_comb begin
      rsp_in      = '0;
      fifo_cmd    = '0;
      peek_go     = 1'b0;
      out_byte_in = out_byte_ff;
      case (req_data.command)
         CMD_READ: begin
            case (req_data.offset)
               OFS_STATUS: rsp_in.read_data = STATUS_BASE |
                                              (fifo_sts.empty ? 8'h00 : STATUS_READY);
               OFS_DATA: begin
                  if (fifo_sts.empty) rsp_in.read_data = latched_ff;
                  else peek_go = accept;
               end
               OFS_OUTPUT: rsp_in.read_data = out_byte_ff;
               default: rsp_in.read_data = 8'h00;
            endcase
         end
         CMD_WRITE: begin
            case (req_data.offset)
               OFS_STATUS: fifo_cmd.pop = accept && req_data.value[POP_BIT] &&
                                          !fifo_sts.empty;
               OFS_OUTPUT: begin
                  out_byte_in      = req_data.value;
                  rsp_in.tx_valid  = 1'b1;
                  rsp_in.tx_byte   = req_data.value;
               end
               default: out_byte_in = out_byte_ff;
            endcase
         end
         CMD_RX: begin
            if (fifo_sts.full) rsp_in.rx_dropped = 1'b1;
            else fifo_cmd.push = accept;
         end
         default: rsp_in = '0;
      endcase
      fifo_cmd.peek = peek_go;
      // Interrupt level as it stands after this beat
      if (fifo_cmd.push) rsp_in.irq_level = 1'b1;
      else if (fifo_cmd.pop) rsp_in.irq_level = !fifo_sts.single;
      else rsp_in.irq_level = !fifo_sts.empty;
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         latched_ff   <= 8'h00;
         out_byte_ff  <= 8'h00;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  out_byte_ff <= out_byte_in;
                  if (peek_go) begin
                     state_ff     <= ST_PEEK;
                     rsp_valid_ff <= 1'b0;
                  end else begin
                     rsp_ff       <= rsp_in;
                     rsp_valid_ff <= 1'b1;
                  end
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_PEEK: begin
               // Head byte now out of the memory; FIFO still holds data
               latched_ff   <= head_byte;
               // read_data, tx_valid, tx_byte, rx_dropped, irq_level
               rsp_ff       <= {head_byte, 1'b0, 8'h00, 1'b0, 1'b1};
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
